// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the sound level meter.
// Each macro expects a clock i_clk and an active-low reset i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/slp2p_pkg.sv -----
// Package for the peak-to-peak sound level meter: widths, level constants,
// configuration register indexes and the leading-one helper. No dependencies.
`default_nettype none

package slp2p_pkg;

    // Converter and field widths.
    localparam int ADC_BITS    = 12;
    localparam int LEVEL_W     = 16;
    localparam int OS_SUM_W    = 20;
    localparam int OS_COUNT_W  = 9;
    localparam int OSR_W       = 4;
    localparam int WIN_W       = 10;
    localparam int TOP_BIT_W   = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;

    // Log2 datapath: mantissa in Q30 and 16 fraction bits.
    localparam int MANT_W      = 31;
    localparam int FRAC_BITS   = 16;
    localparam int LOG_W       = TOP_BIT_W + FRAC_BITS;
    localparam int SLOPE_W     = 27;
    localparam int PROD_W      = LOG_W + SLOPE_W;
    localparam int SUM_W       = 33;

    // 20*log10(2)*256 and the dB offset of the microphone chain, both in Q16.
    localparam logic [SLOPE_W-1:0] LVL_SLOPE_Q16  = 27'd101008905;
    localparam logic [SUM_W-1:0]   LVL_OFFSET_Q16 = 33'd1243293541;
    localparam logic [SUM_W-1:0]   LVL_ROUND      = 33'd32768;

    // Register reset values and limits.
    localparam logic [OSR_W-1:0] OSR_BITS_RESET = 4'd4;
    localparam logic [OSR_W-1:0] OSR_BITS_MAX   = 4'd8;
    localparam logic [WIN_W-1:0] WIN_LEN_RESET  = 10'd100;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_OSR_BITS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WIN_LEN  = 2'd1;

    // Position of the highest set bit; zero for a zero input.
    function automatic logic [TOP_BIT_W-1:0] top_bit(input logic [ADC_BITS-1:0] v);
        logic [TOP_BIT_W-1:0] n;
        n = '0;
        for (int i = 0; i < ADC_BITS; i++) begin
            if (v[i]) begin
                n = TOP_BIT_W'(i);
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sound_level_peak_to_peak_db_unit.sv -----
// Peak-to-peak sound level meter for one microphone channel.
// Depends on slp2p_pkg and assert_macros.svh.
//
// Takes one converter sample per clock while o_in_ready is high. Samples are
// averaged in groups of 2^oversample_bits (values above 8 act as 8); over a
// window of window_length averaged samples (0 or 1 acts as 1) the minimum and
// maximum are tracked, and each closed window gives one result beat with
// peak_to_peak, the level in 1/256 dB and a silent flag (peak_to_peak zero,
// level zero). The fraction bits of log2(peak_to_peak) come from a 16-stage
// squaring pipeline, one bit and one 31x31 multiply per stage. Input ready
// drops only when the output register and the one-beat skid stage behind it
// are both full. Configuration writes are taken in any cycle and should be
// made while the block is idle.
`default_nettype none

`include "assert_macros.svh"

module sound_level_peak_to_peak_db_unit
    import slp2p_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Sample input channel.
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [ADC_BITS-1:0]    i_adc_sample,
    // Result output channel.
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [ADC_BITS-1:0]         o_peak_to_peak,
    output logic [LEVEL_W-1:0]          o_level_db,
    output logic                        o_silent,
    // Configuration write channel.
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int SQ_STAGES = FRAC_BITS;

    // Configuration registers.
    logic [OSR_W-1:0] r_osr_bits;
    logic [WIN_W-1:0] r_win_len;

    // Measurement state.
    logic [OS_SUM_W-1:0]   r_os_sum;
    logic [OS_COUNT_W-1:0] r_os_count;
    logic [WIN_W-1:0]      r_win_count;
    logic [ADC_BITS-1:0]   r_min;
    logic [ADC_BITS-1:0]   r_max;

    // Pipeline stages.
    logic                  r_a_valid;
    logic [ADC_BITS-1:0]   r_a_sample;
    logic                  r_b_valid;
    logic [ADC_BITS-1:0]   r_b_avg;
    logic                  r_c_valid;
    logic [ADC_BITS-1:0]   r_c_min;
    logic [ADC_BITS-1:0]   r_c_max;

    logic                  r_sq_valid  [0:SQ_STAGES];
    logic [MANT_W-1:0]     r_sq_x      [0:SQ_STAGES];
    logic [FRAC_BITS-1:0]  r_sq_frac   [0:SQ_STAGES];
    logic [TOP_BIT_W-1:0]  r_sq_n      [0:SQ_STAGES];
    logic [ADC_BITS-1:0]   r_sq_pp     [0:SQ_STAGES];
    logic                  r_sq_silent [0:SQ_STAGES];

    logic                  r_m_valid;
    logic [PROD_W-1:0]     r_m_prod;
    logic [ADC_BITS-1:0]   r_m_pp;
    logic                  r_m_silent;

    // Output register and skid stage.
    logic                  r_out_valid;
    logic [ADC_BITS-1:0]   r_out_pp;
    logic [LEVEL_W-1:0]    r_out_level;
    logic                  r_out_silent;
    logic                  r_skid_valid;
    logic [ADC_BITS-1:0]   r_skid_pp;
    logic [LEVEL_W-1:0]    r_skid_level;
    logic                  r_skid_silent;

    // Combinational signals.
    logic                  en;
    logic [OSR_W-1:0]      bits_eff;
    logic [OS_COUNT_W-1:0] os_limit;
    logic [OS_SUM_W-1:0]   os_sum_inc;
    logic [OS_COUNT_W-1:0] os_count_inc;
    logic                  os_done;
    logic [ADC_BITS-1:0]   avg;
    logic [WIN_W-1:0]      win_len_eff;
    logic [WIN_W-1:0]      win_count_inc;
    logic                  win_done;
    logic [ADC_BITS-1:0]   min_nxt;
    logic [ADC_BITS-1:0]   max_nxt;
    logic [ADC_BITS-1:0]   d_pp;
    logic [TOP_BIT_W-1:0]  d_n;
    logic [MANT_W-1:0]     d_x;
    logic [2*MANT_W-1:0]   sq_prod     [0:SQ_STAGES-1];
    logic [MANT_W-1:0]     sq_x_nxt    [0:SQ_STAGES-1];
    logic                  sq_bit      [0:SQ_STAGES-1];
    logic [SUM_W-1:0]      lvl_sum;
    logic                  p_valid;
    logic [LEVEL_W-1:0]    p_level;

    // The pipeline ahead of the output register moves while the skid stage is free.
    assign en          = !r_skid_valid;
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;

    // Oversampling accumulator.
    always_comb begin
        bits_eff     = (r_osr_bits > OSR_BITS_MAX) ? OSR_BITS_MAX : r_osr_bits;
        os_limit     = OS_COUNT_W'(1) << bits_eff;
        os_sum_inc   = r_os_sum + OS_SUM_W'(r_a_sample);
        os_count_inc = r_os_count + OS_COUNT_W'(1);
        os_done      = os_count_inc >= os_limit;
        avg          = ADC_BITS'(os_sum_inc >> bits_eff);
    end

    // Window minimum and maximum; the first sample of a window loads both.
    always_comb begin
        win_len_eff   = (r_win_len == '0) ? WIN_W'(1) : r_win_len;
        win_count_inc = r_win_count + WIN_W'(1);
        win_done      = win_count_inc >= win_len_eff;
        if (r_win_count == '0) begin
            min_nxt = r_b_avg;
            max_nxt = r_b_avg;
        end else begin
            min_nxt = (r_b_avg < r_min) ? r_b_avg : r_min;
            max_nxt = (r_b_avg > r_max) ? r_b_avg : r_max;
        end
    end

    // Peak-to-peak and mantissa normalization into Q30.
    always_comb begin
        d_pp = r_c_max - r_c_min;
        d_n  = top_bit(d_pp);
        d_x  = MANT_W'(d_pp) << (5'd30 - {1'b0, d_n});
    end

    // One squaring step per stage: square, then renormalize if the value
    // reached two, which yields one fraction bit of the logarithm.
    always_comb begin
        for (int k = 0; k < SQ_STAGES; k++) begin
            sq_prod[k] = r_sq_x[k] * r_sq_x[k];
            sq_bit[k]  = sq_prod[k][2*MANT_W-1];
            if (sq_bit[k]) begin
                sq_x_nxt[k] = sq_prod[k][2*MANT_W-1:MANT_W];
            end else begin
                sq_x_nxt[k] = sq_prod[k][2*MANT_W-2:MANT_W-1];
            end
        end
    end

    // Scaled level with offset and rounding.
    always_comb begin
        lvl_sum = SUM_W'(r_m_prod[PROD_W-1:16]) + LVL_OFFSET_Q16 + LVL_ROUND;
        p_level = r_m_silent ? '0 : lvl_sum[31:16];
        p_valid = r_m_valid && en;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_osr_bits <= OSR_BITS_RESET;
            r_win_len  <= WIN_LEN_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_OSR_BITS: r_osr_bits <= i_cfg_data[OSR_W-1:0];
                CFG_WIN_LEN:  r_win_len  <= i_cfg_data[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Front end: input register, accumulator and window tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_os_sum    <= '0;
            r_os_count  <= '0;
            r_win_count <= '0;
            r_min       <= '0;
            r_max       <= '0;
        end else if (en) begin
            r_a_valid  <= i_in_valid;
            r_a_sample <= i_adc_sample;

            r_b_valid <= r_a_valid && os_done;
            r_b_avg   <= avg;
            if (r_a_valid) begin
                r_os_sum   <= os_done ? '0 : os_sum_inc;
                r_os_count <= os_done ? '0 : os_count_inc;
            end

            r_c_valid <= r_b_valid && win_done;
            r_c_min   <= min_nxt;
            r_c_max   <= max_nxt;
            if (r_b_valid) begin
                r_min       <= min_nxt;
                r_max       <= max_nxt;
                r_win_count <= win_done ? '0 : win_count_inc;
            end
        end
    end

    // Log2 pipeline and slope multiply.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= SQ_STAGES; k++) begin
                r_sq_valid[k] <= 1'b0;
            end
            r_m_valid <= 1'b0;
        end else if (en) begin
            r_sq_valid[0]  <= r_c_valid;
            r_sq_x[0]      <= d_x;
            r_sq_frac[0]   <= '0;
            r_sq_n[0]      <= d_n;
            r_sq_pp[0]     <= d_pp;
            r_sq_silent[0] <= (d_pp == '0);
            for (int k = 0; k < SQ_STAGES; k++) begin
                r_sq_valid[k+1]  <= r_sq_valid[k];
                r_sq_x[k+1]      <= sq_x_nxt[k];
                r_sq_frac[k+1]   <= {r_sq_frac[k][FRAC_BITS-2:0], sq_bit[k]};
                r_sq_n[k+1]      <= r_sq_n[k];
                r_sq_pp[k+1]     <= r_sq_pp[k];
                r_sq_silent[k+1] <= r_sq_silent[k];
            end
            r_m_valid  <= r_sq_valid[SQ_STAGES];
            r_m_prod   <= PROD_W'({r_sq_n[SQ_STAGES], r_sq_frac[SQ_STAGES]}) *
                          PROD_W'(LVL_SLOPE_Q16);
            r_m_pp     <= r_sq_pp[SQ_STAGES];
            r_m_silent <= r_sq_silent[SQ_STAGES];
        end
    end

    // Output register with a one-beat skid stage behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_out_pp     <= r_skid_pp;
                r_out_level  <= r_skid_level;
                r_out_silent <= r_skid_silent;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= p_valid;
                r_out_pp     <= r_m_pp;
                r_out_level  <= p_level;
                r_out_silent <= r_m_silent;
            end
        end else if (p_valid) begin
            r_skid_valid  <= 1'b1;
            r_skid_pp     <= r_m_pp;
            r_skid_level  <= p_level;
            r_skid_silent <= r_m_silent;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_peak_to_peak = r_out_pp;
    assign o_level_db     = r_out_level;
    assign o_silent       = r_out_silent;

    // A beat in the skid stage always has one ahead of it in the output register.
    `ASSERT_IMPLIES(a_skid_behind_out, r_skid_valid, r_out_valid, "skid full with output empty")
    // A stalled output with a beat arriving must park it in the skid stage.
    `ASSERT_NEXT(a_skid_catches, o_out_valid && !i_out_ready && r_m_valid && en, r_skid_valid, "result beat dropped on stall")
    // A silent result carries zero peak-to-peak and zero level.
    `ASSERT_IMPLIES(a_silent_zero, o_out_valid && o_silent, o_peak_to_peak == '0 && o_level_db == '0, "silent beat with nonzero fields")
    // The group count never passes the largest group size.
    `ASSERT_ALWAYS(a_os_count_range, r_os_count <= (OS_COUNT_W'(1) << OSR_BITS_MAX), "oversample count overran")
    // The window count stays below the largest window.
    `ASSERT_ALWAYS(a_win_count_range, r_win_count != '1, "window count overran")

endmodule

`default_nettype wire
